>>> rtl/psc_pkg.sv
// Shared types and constants of the pixel substitution cipher unit.
package psc_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TABLE_AW = $clog2(TABLE_SIZE);
  localparam int NUM_CH = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SUM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 8'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [19:0] pattern_value;
    logic [19:0] pixel_index;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_beat_t;

  typedef struct packed {
    logic                              load;
    logic                              dir;
    logic [NUM_CH-1:0][TABLE_AW-1:0]   addr;
    logic [NUM_CH-1:0][7:0]            post;
    logic [TABLE_AW-1:0]               table_index;
    logic [7:0]                        table_value;
  } qent_t;

endpackage

>>> rtl/psc_front.sv
// Front end: configuration registers, beat classification and address preparation.
module psc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  psc_pkg::in_beat_t               in_data,
  output psc_pkg::qent_t                  entry
);

  logic [15:0] key_sum_r;
  logic        direction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_sum_r   <= '0;
      direction_r <= psc_pkg::DIR_ENCRYPT;
    end else if (cfg_we) begin
      case (cfg_index)
        psc_pkg::CFG_KEY_SUM:   key_sum_r   <= cfg_data[15:0];
        psc_pkg::CFG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A value is congruent to the sum of its base-4 digits modulo three.
  function automatic logic [1:0] mod3_20(input logic [19:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int k = 0; k < 10; k++) begin
      s = s + {3'b000, v[2*k +: 2]};
    end
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b00, s[4]};
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  logic [15:0]                 prod;
  logic [7:0]                  off;
  logic [7:0]                  neg;
  logic [7:0]                  pos_o;
  logic [7:0]                  neg_o;
  logic [1:0]                  sel;
  logic [7:0]                  rot;
  logic [psc_pkg::NUM_CH-1:0][7:0] ch;
  logic [psc_pkg::NUM_CH-1:0][7:0] add;

  always_comb begin
    prod  = {8'h00, key_sum_r[7:0]} * {8'h00, in_data.pattern_value[7:0]};
    off   = prod[7:0];
    neg   = 8'h00 - off;
    pos_o = (direction_r == psc_pkg::DIR_DECRYPT) ? neg : off;
    neg_o = (direction_r == psc_pkg::DIR_DECRYPT) ? off : neg;
    sel   = mod3_20(in_data.pattern_value);
    rot   = in_data.pixel_index[7:0];
    ch[0] = in_data.pixel_red;
    ch[1] = in_data.pixel_green;
    ch[2] = in_data.pixel_blue;
    case (sel)
      2'd0: begin
        add[0] = 8'h00; add[1] = pos_o; add[2] = neg_o;
      end
      2'd1: begin
        add[0] = neg_o; add[1] = 8'h00; add[2] = pos_o;
      end
      default: begin
        add[0] = pos_o; add[1] = neg_o; add[2] = 8'h00;
      end
    endcase
    entry.load        = (in_data.req_type == psc_pkg::REQ_LOAD);
    entry.dir         = direction_r;
    entry.table_index = in_data.table_index;
    entry.table_value = in_data.table_value;
    for (int c = 0; c < psc_pkg::NUM_CH; c++) begin
      if (direction_r == psc_pkg::DIR_DECRYPT) begin
        entry.addr[c] = ch[c];
        entry.post[c] = add[c] - rot;
      end else begin
        entry.addr[c] = ch[c] + add[c] + rot;
        entry.post[c] = 8'h00;
      end
    end
  end

endmodule

>>> rtl/psc_queue.sv
// Short first-in first-out queue between the front and back ends.
module psc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  psc_pkg::qent_t  push_data,
  input  logic            pop,
  output psc_pkg::qent_t  head,
  output logic            empty,
  output logic            full
);

  psc_pkg::qent_t                  mem_r [psc_pkg::QUEUE_DEPTH];
  logic [psc_pkg::QUEUE_AW-1:0]    wr_ptr_r;
  logic [psc_pkg::QUEUE_AW-1:0]    rd_ptr_r;
  logic [psc_pkg::QUEUE_AW:0]      count_r;
  logic [psc_pkg::QUEUE_AW:0]      count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (psc_pkg::QUEUE_AW + 1)'(psc_pkg::QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/psc_back.sv
// Back end: substitution tables, table lookups and the output register.
module psc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  psc_pkg::qent_t     head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output psc_pkg::out_beat_t out_data
);

  logic [7:0] sbox_mem [psc_pkg::NUM_CH][psc_pkg::TABLE_SIZE];
  logic [7:0] inv_mem  [psc_pkg::NUM_CH][psc_pkg::TABLE_SIZE];

  logic                            adv;
  logic                            a_valid_r;
  logic [psc_pkg::NUM_CH-1:0][7:0] a_post_r;
  logic [psc_pkg::NUM_CH-1:0][7:0] rd_r;
  logic                            out_valid_r;
  psc_pkg::out_beat_t              out_data_r;

  assign adv       = !out_valid_r || !out_stall;
  assign pop       = adv && !empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < psc_pkg::NUM_CH; c++) begin
      if (pop && head.load) begin
        sbox_mem[c][head.table_index] <= head.table_value;
        inv_mem[c][head.table_value]  <= head.table_index;
      end
      if (adv) begin
        rd_r[c] <= (head.dir == psc_pkg::DIR_DECRYPT) ? inv_mem[c][head.addr[c]]
                                                       : sbox_mem[c][head.addr[c]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= pop && !head.load;
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_post_r             <= head.post;
      out_data_r.out_red   <= rd_r[0] + a_post_r[0];
      out_data_r.out_green <= rd_r[1] + a_post_r[1];
      out_data_r.out_blue  <= rd_r[2] + a_post_r[2];
    end
  end

endmodule

>>> rtl/pixel_substitution_cipher_unit.sv
// Top level of the pixel substitution cipher unit.
// The unit takes one beat per clock cycle while in_stall is low, either a pixel
// or a table load, and returns one result beat per pixel through the queue, the
// table read register and the output register. The table read happens at the
// edge that pops the queue, and the output register takes the final add. The
// sustained rate of one beat per cycle without an output stall is set by the
// tables, held as three copies each, one per colour channel, so that every
// channel has its own read port. A four-beat queue decouples the input from
// the result side, so input beats keep flowing while a result is held back.
// Both tables have no reset contents and must be loaded before pixels use them;
// the user must write configuration only while idle; the unit does not check.
module pixel_substitution_cipher_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  psc_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output psc_pkg::out_beat_t              out_data
);

  psc_pkg::qent_t front_entry;
  psc_pkg::qent_t q_head;
  logic           q_empty;
  logic           q_full;
  logic           q_pop;
  logic           in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  psc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .entry     (front_entry)
  );

  psc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  psc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
